[sv/erf_pkg.sv]
// Package for the expiring replay filter: table size, item and slot
// layouts, status codes and controller state. Depends on nothing.
package erf_pkg;

    localparam int ENTRIES   = 64;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int CNT_W     = IDX_W + 1;
    localparam int TIME_W    = 63;
    localparam int WORD_W    = 64;
    localparam int KEY_WORDS = 4;

    typedef logic [1:0] status_t;
    localparam status_t ST_FRESH  = 2'd0;
    localparam status_t ST_REPLAY = 2'd1;
    localparam status_t ST_FULL   = 2'd2;

    typedef struct packed {
        logic [TIME_W-1:0]                now_sec;
        logic [TIME_W-1:0]                exp_sec;
        logic [KEY_WORDS-1:0][WORD_W-1:0] key;
    } item_t;

    typedef struct packed {
        logic [TIME_W-1:0]                expiry;
        logic [KEY_WORDS-1:0][WORD_W-1:0] key;
    } slot_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        slot_t            wr_data;
    } ram_req_t;

    typedef struct packed {
        logic    idle;
        logic    done;
        status_t status;
    } ctrl_stat_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

endpackage

[sv/erf_slot_ram.sv]
// Slot table memory: one row per slot holding expiry and 256-bit key.
// Synchronous read: rd_data is registered. Depends on erf_pkg.
module erf_slot_ram
    import erf_pkg::*;
(
    input  logic     clk,
    input  ram_req_t req,
    output slot_t    rd_data
);

    slot_t mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

[sv/erf_ctrl.sv]
// Scan controller: walks the slot table, compares keys, purges expired
// slots, picks the lowest free slot and inserts. Depends on erf_pkg.
module erf_ctrl
    import erf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  item_t      item,
    input  logic       res_free,
    input  slot_t      rd_data,
    output ram_req_t   ram_req,
    output ctrl_stat_t stat
);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   rd_cnt_reg;
    logic               cmp_valid_reg;
    logic [IDX_W-1:0]   cmp_idx_reg;
    logic               seen_reg;
    logic               have_free_reg;
    logic [IDX_W-1:0]   free_slot_reg;
    logic [ENTRIES-1:0] valid_reg;

    logic    slot_live;
    logic    key_hit;
    logic    expired;
    logic    slot_free;
    logic    last_cmp;
    logic    reading;
    status_t result;

    assign slot_live = valid_reg[cmp_idx_reg];
    assign key_hit   = slot_live && (rd_data.key == item.key);
    assign expired   = slot_live && (rd_data.expiry < item.now_sec);
    assign slot_free = !slot_live || expired;
    assign last_cmp  = cmp_valid_reg && (cmp_idx_reg == IDX_W'(ENTRIES - 1));
    assign reading   = (state_reg == S_SCAN) && (rd_cnt_reg < CNT_W'(ENTRIES));

    always_comb
    begin
        priority if (seen_reg)
            result = ST_REPLAY;
        else if (!have_free_reg)
            result = ST_FULL;
        else
            result = ST_FRESH;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (last_cmp)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (res_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        ram_req.rd_en       = reading;
        ram_req.rd_addr     = rd_cnt_reg[IDX_W-1:0];
        ram_req.wr_en       = 1'b0;
        ram_req.wr_addr     = free_slot_reg;
        ram_req.wr_data.expiry = item.exp_sec;
        ram_req.wr_data.key    = item.key;
        stat.idle           = 1'b0;
        stat.done           = 1'b0;
        stat.status         = result;
        unique case (state_reg)
            S_IDLE:
            begin
                stat.idle = 1'b1;
            end
            S_SCAN:
            begin
            end
            S_FINISH:
            begin
                stat.done     = res_free;
                ram_req.wr_en = res_free && (result == ST_FRESH);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_cnt_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            cmp_idx_reg   <= '0;
            seen_reg      <= 1'b0;
            have_free_reg <= 1'b0;
            free_slot_reg <= '0;
            valid_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_IDLE)
            begin
                rd_cnt_reg    <= '0;
                cmp_valid_reg <= 1'b0;
                seen_reg      <= 1'b0;
                have_free_reg <= 1'b0;
            end
            else
            begin
                // compare stage works on the row read in the previous cycle
                cmp_valid_reg <= reading;
                cmp_idx_reg   <= rd_cnt_reg[IDX_W-1:0];
                if (reading)
                    rd_cnt_reg <= rd_cnt_reg + CNT_W'(1);
                if (cmp_valid_reg)
                begin
                    if (key_hit)
                        seen_reg <= 1'b1;
                    if (expired)
                        valid_reg[cmp_idx_reg] <= 1'b0;
                    if (slot_free && !have_free_reg)
                    begin
                        have_free_reg <= 1'b1;
                        free_slot_reg <= cmp_idx_reg;
                    end
                end
                if ((state_reg == S_FINISH) && res_free && (result == ST_FRESH))
                    valid_reg[free_slot_reg] <= 1'b1;
            end
        end
    end

endmodule

[sv/expiring_replay_filter.sv]
// Channel | handshake          | word
// --------+--------------------+--------------------------------------------
// in      | in_valid/in_ready  | now_seconds, expiry_time, key_word0..3
// out     | out_valid/out_ready| status (0 fresh, 1 replay, 2 full)
//
// Each word passes through the idle accept cycle, a scan that reads one slot row
// per cycle from the slot memory, one trailing compare, and an insert/result
// step that waits until the output register is free.
// in_ready is high only while the scan controller is idle.
// A finished status sits in the output register; the next word is accepted
// while it waits, and its insert holds until the register frees up.
// Reset empties the table at once through per-slot valid flops.
// Top level of the expiring replay filter. Depends on erf_pkg, erf_slot_ram
// and erf_ctrl.
module expiring_replay_filter
    import erf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [TIME_W-1:0] now_seconds,
    input  logic [TIME_W-1:0] expiry_time,
    input  logic [WORD_W-1:0] key_word0,
    input  logic [WORD_W-1:0] key_word1,
    input  logic [WORD_W-1:0] key_word2,
    input  logic [WORD_W-1:0] key_word3,
    output logic              out_valid,
    input  logic              out_ready,
    output status_t           status
);

    item_t      item_reg;
    logic       out_valid_reg;
    status_t    status_reg;
    logic       accept;
    logic       res_free;
    ram_req_t   ram_req;
    slot_t      rd_data;
    ctrl_stat_t stat;

    assign in_ready  = stat.idle;
    assign accept    = in_valid && in_ready;
    assign res_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign status    = status_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.now_sec <= now_seconds;
            item_reg.exp_sec <= expiry_time;
            item_reg.key     <= {key_word3, key_word2, key_word1, key_word0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stat.done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat.done)
            status_reg <= stat.status;
    end

    erf_slot_ram u_ram (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (rd_data)
    );

    erf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .item     (item_reg),
        .res_free (res_free),
        .rd_data  (rd_data),
        .ram_req  (ram_req),
        .stat     (stat)
    );

endmodule

[sim/expiring_replay_filter_tb.sv]
// Testbench for expiring_replay_filter: drives challenge words, predicts the
// status of each one from its own copy of the slot table and checks every result.
// Depends on erf_pkg and the expiring_replay_filter RTL.
module expiring_replay_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import erf_pkg::*;

    typedef logic [KEY_WORDS*WORD_W-1:0] key_t;

    typedef struct {
        key_t              key;
        logic [TIME_W-1:0] exp;
    } sent_entry_t;

    localparam logic [TIME_W-1:0] TIME_MAX     = '1;
    localparam int                SCAN_CYCLES  = ENTRIES + 3;
    localparam int                RANDOM_WORDS = 800;
    localparam int                QUIET_TAIL   = 100;
    localparam int                HOLD_CYCLES  = 600;
    localparam int                LIMIT_CYCLES = 600000;

    // Tracks the slot table and the statuses still owed by the block.
    class replay_status_book;
        bit                slot_live [ENTRIES];
        logic [TIME_W-1:0] slot_exp  [ENTRIES];
        key_t              slot_key  [ENTRIES];
        status_t           due_status [$];
        int                mismatches;
        int                results_seen;
        int                n_fresh;
        int                n_replay;
        int                n_full;

        function new();
            foreach (slot_live[s])
                slot_live[s] = 1'b0;
        endfunction

        function void note_word(logic [TIME_W-1:0] now_s, logic [TIME_W-1:0] exp_s,
                                key_t key);
            bit      seen;
            bit      have_free;
            int      free_idx;
            status_t st;
            seen      = 1'b0;
            have_free = 1'b0;
            free_idx  = 0;
            for (int s = 0; s < ENTRIES; s++)
            begin
                if (slot_live[s])
                begin
                    // a match counts even when the slot is purged in this pass
                    if (slot_key[s] == key)
                        seen = 1'b1;
                    if (slot_exp[s] < now_s)
                        slot_live[s] = 1'b0;
                end
                if (!slot_live[s] && !have_free)
                begin
                    have_free = 1'b1;
                    free_idx  = s;
                end
            end
            if (seen)
            begin
                st = ST_REPLAY;
                n_replay++;
            end
            else if (!have_free)
            begin
                st = ST_FULL;
                n_full++;
            end
            else
            begin
                slot_live[free_idx] = 1'b1;
                slot_exp[free_idx]  = exp_s;
                slot_key[free_idx]  = key;
                st = ST_FRESH;
                n_fresh++;
            end
            due_status.push_back(st);
        endfunction

        function void check_status(status_t got);
            status_t want;
            results_seen++;
            if (due_status.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: status %0d arrived with no word outstanding", got);
            end
            else
            begin
                want = due_status.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: result %0d status expected %0d got %0d",
                                 results_seen, want, got);
                end
            end
        endfunction

        function int pending();
            return due_status.size();
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [TIME_W-1:0] now_seconds;
    logic [TIME_W-1:0] expiry_time;
    logic [WORD_W-1:0] key_word0;
    logic [WORD_W-1:0] key_word1;
    logic [WORD_W-1:0] key_word2;
    logic [WORD_W-1:0] key_word3;
    logic              out_valid;
    logic              out_ready;
    status_t           status;

    replay_status_book book;
    sent_entry_t       recent_words [$];
    bit                tx_idle_en;
    bit                rx_idle_en;
    int                hold_request;
    int                hold_left;
    int                stall_left;
    int                words_sent;
    int                cycle_count;

    expiring_replay_filter uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .now_seconds (now_seconds),
        .expiry_time (expiry_time),
        .key_word0   (key_word0),
        .key_word1   (key_word1),
        .key_word2   (key_word2),
        .key_word3   (key_word3),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("ERROR: timeout after %0d cycles, %0d statuses outstanding",
                     cycle_count, book.pending());
            $display("expiring_replay_filter verification failed");
            $finish;
        end
    end

    // Result side: check each accepted word, then pick the next ready level.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                book.check_status(status);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (rx_idle_en && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(0, 13);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    function automatic logic [TIME_W-1:0] rand_time();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[TIME_W-1:0];
    endfunction

    function automatic key_t rand_key();
        return {$urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic sent_entry_t pick_recent();
        return recent_words[$urandom_range(0, recent_words.size() - 1)];
    endfunction

    task automatic send_word(input logic [TIME_W-1:0] now_s,
                             input logic [TIME_W-1:0] exp_s, input key_t key);
        int          gap;
        sent_entry_t ent;
        gap = 0;
        if (words_sent >= RANDOM_WORDS + 15 - QUIET_TAIL)
        begin
            tx_idle_en = 1'b0;
            rx_idle_en = 1'b0;
        end
        if (tx_idle_en && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 14);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        now_seconds <= now_s;
        expiry_time <= exp_s;
        key_word0   <= key[63:0];
        key_word1   <= key[127:64];
        key_word2   <= key[191:128];
        key_word3   <= key[255:192];
        do @(posedge clk); while (!in_ready);
        book.note_word(now_s, exp_s, key);
        ent.key = key;
        ent.exp = exp_s;
        recent_words.push_back(ent);
        if (recent_words.size() > 128)
            void'(recent_words.pop_front());
        words_sent++;
    endtask

    // Drop valid and hold until every owed status is back.
    task automatic wait_all_results();
        in_valid <= 1'b0;
        while (book.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        key_t              k_zero;
        key_t              k_ones;
        key_t              k_a;
        key_t              k_b;
        key_t              k_one_off;
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] now_s;
        logic [TIME_W-1:0] exp_s;
        key_t              key;
        sent_entry_t       h;
        int                seg;
        int                kind;
        int                n;
        int                pick;

        book        = new();
        clk         = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        now_seconds = '0;
        expiry_time = '0;
        key_word0   = '0;
        key_word1   = '0;
        key_word2   = '0;
        key_word3   = '0;
        out_ready   = 1'b0;
        tx_idle_en  = 1'b1;
        rx_idle_en  = 1'b1;

        k_zero    = '0;
        k_ones    = '1;
        k_a       = {4{64'h5555_5555_5555_5555}};
        k_b       = {4{64'hAAAA_AAAA_AAAA_AAAA}};
        k_one_off = {64'hFFFF_FFFF_FFFF_FFFF, 64'h0,
                     64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: equal times, purge-then-reuse, expired matches, extremes.
        send_word(0, 0, k_zero);
        send_word(0, 0, k_zero);
        send_word(1, TIME_MAX, k_ones);
        send_word(1, 5, k_zero);
        send_word(1, 5, k_one_off);
        send_word(6, 100, k_zero);
        send_word(6, 2, k_a);
        send_word(6, 100, k_a);
        send_word(7, 100, k_a);
        send_word(TIME_MAX, TIME_MAX, k_b);
        send_word(TIME_MAX, TIME_MAX, k_ones);
        send_word(TIME_MAX, 0, k_zero);
        send_word(63'h2AAA_AAAA_AAAA_AAAA, 63'h5555_5555_5555_5555, k_a);
        send_word(63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA, k_b);
        send_word(63'h5555_5555_5555_5556, 10, k_a);

        t   = 1000;
        seg = 0;
        while (words_sent < RANDOM_WORDS + 15)
        begin
            seg++;
            kind = (seg == 1) ? 0 : $urandom_range(0, 9);
            tx_idle_en = ($urandom_range(0, 3) != 0);
            rx_idle_en = ($urandom_range(0, 3) != 0);
            if (seg == 3)
                hold_request = HOLD_CYCLES;
            if (seg == 6)
                wait_all_results();

            if (kind <= 2)
            begin
                // Fill: jump past all short expiries, then overrun the table.
                t = t + 50000;
                n = $urandom_range(80, 90);
                for (int i = 0; i < n; i++)
                begin
                    if (i > 0 && $urandom_range(0, 9) == 0)
                        key = pick_recent().key;
                    else
                        key = rand_key();
                    send_word(t, t + $urandom_range(100, 10000), key);
                end
            end
            else if (kind <= 7)
            begin
                n = $urandom_range(20, 60);
                for (int i = 0; i < n; i++)
                begin
                    t     = t + $urandom_range(0, 30);
                    now_s = t;
                    pick  = $urandom_range(0, 9);
                    if (pick < 4)
                        key = pick_recent().key;
                    else if (pick == 4)
                    begin
                        // land exactly on a stored expiry
                        h     = pick_recent();
                        key   = h.key;
                        now_s = h.exp;
                    end
                    else
                        key = rand_key();
                    pick = $urandom_range(0, 9);
                    if (pick == 0)
                        exp_s = (now_s > 64) ? now_s - $urandom_range(1, 64) : '0;
                    else if (pick == 1)
                        exp_s = now_s;
                    else
                        exp_s = now_s + $urandom_range(1, 400);
                    send_word(now_s, exp_s, key);
                end
            end
            else if (kind == 8)
            begin
                t = t + 100000;
                send_word(t, t + $urandom_range(0, 1000), rand_key());
            end
            else
            begin
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++)
                begin
                    key = ($urandom_range(0, 1) == 0) ? rand_key() : pick_recent().key;
                    send_word(rand_time(), rand_time(), key);
                end
            end
        end

        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        wait_all_results();
        repeat (3 * SCAN_CYCLES) @(posedge clk);

        $display("Summary: %0d words, %0d statuses: %0d stored, %0d replays, %0d full",
                 words_sent, book.results_seen, book.n_fresh, book.n_replay, book.n_full);
        $display("Summary: time extremes, purges, overruns, a %0d-cycle output hold, a drain",
                 HOLD_CYCLES);
        if (book.mismatches == 0 && book.pending() == 0)
            $display("expiring_replay_filter verification clean");
        else
            $display("expiring_replay_filter verification failed");
        $finish;
    end

endmodule

[expiring_replay_filter.f]
sv/erf_pkg.sv
sv/erf_slot_ram.sv
sv/erf_ctrl.sv
sv/expiring_replay_filter.sv
sim/expiring_replay_filter_tb.sv
